>>> sv/dpr_pkg.sv
// Shared types and constants for the display response deframer.
// No dependencies; imported by dpr_decode, display_response_deframer and dpr_checker.
package dpr_pkg;

    typedef enum logic [2:0] {
        KIND_TOUCH    = 3'd0,
        KIND_COORD    = 3'd1,
        KIND_NUMBER   = 3'd2,
        KIND_TEXT     = 3'd3,
        KIND_OVERFLOW = 3'd4
    } kind_t;

    localparam logic [7:0]  TERM_BYTE   = 8'hFF;
    localparam logic [7:0]  TAG_TOUCH   = 8'h65;
    localparam logic [7:0]  TAG_COORD   = 8'h67;
    localparam logic [7:0]  TAG_NUMBER  = 8'h71;
    localparam logic [7:0]  DIGIT_BASE  = 8'h30;
    localparam logic [39:0] PAGE_TAG    = 40'h70_61_67_65_3D;       // "page="
    localparam logic [55:0] REFRESH_TAG = 56'h72_65_66_72_65_73_68; // "refresh"

    // leading bytes of a frame kept in flops for decoding
    localparam int HDR_LEN = 7;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  page;
        logic [7:0]  comp;
        logic [7:0]  st;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] num;
        logic [7:0]  ch;
        logic [5:0]  tlen;
        logic        hint;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       is_text;
        logic       page_set;
        logic [7:0] new_page;
        logic       hint;
        logic [5:0] tlen;
        result_t    res;
    } dec_t;

endpackage

>>> sv/dpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/dpr_decode.sv
// Frame classifier: turns the header bytes and fill count into one event.
// Depends on dpr_pkg.
module dpr_decode #(
    parameter int FRAME_MAX = 32
) (
    input  logic [dpr_pkg::HDR_LEN-1:0][7:0]   hdr,
    input  logic [$clog2(FRAME_MAX+1)-1:0]     fill,
    input  logic [7:0]                         page_cur,
    output dpr_pkg::dec_t                      dec
);
    import dpr_pkg::*;

    localparam int FW = $clog2(FRAME_MAX + 1);

    logic is_touch;
    logic is_coord;
    logic is_number;
    logic is_page;
    logic is_refresh;

    assign is_touch   = (fill >= FW'(4)) && (hdr[0] == TAG_TOUCH);
    assign is_coord   = (fill >= FW'(6)) && (hdr[0] == TAG_COORD);
    assign is_number  = (fill >= FW'(5)) && (hdr[0] == TAG_NUMBER);
    assign is_page    = (fill >= FW'(6)) && ({hdr[0], hdr[1], hdr[2], hdr[3], hdr[4]} == PAGE_TAG);
    assign is_refresh = (fill >= FW'(7))
                        && ({hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6]}
                            == REFRESH_TAG);

    always_comb
    begin
        dec          = '0;
        dec.res.last = 1'b1;
        if (is_touch)
        begin
            dec.page_set  = 1'b1;
            dec.new_page  = hdr[1];
            dec.res.kind  = KIND_TOUCH;
            dec.res.page  = hdr[1];
            dec.res.comp  = hdr[2];
            dec.res.st    = hdr[3];
        end
        else if (is_coord)
        begin
            dec.res.kind  = KIND_COORD;
            dec.res.page  = page_cur;
            dec.res.st    = hdr[5];
            dec.res.x     = {hdr[1], hdr[2]};
            dec.res.y     = {hdr[3], hdr[4]};
        end
        else if (is_number)
        begin
            dec.res.kind  = KIND_NUMBER;
            dec.res.page  = page_cur;
            dec.res.num   = {hdr[4], hdr[3], hdr[2], hdr[1]};
        end
        else
        begin
            dec.is_text   = 1'b1;
            dec.res.kind  = KIND_TEXT;
            dec.page_set  = is_page;
            dec.new_page  = hdr[5] - DIGIT_BASE;
            dec.hint      = is_page || is_refresh;
            // a full frame loses its last character
            dec.tlen      = (fill == FW'(FRAME_MAX)) ? 6'(FRAME_MAX - 1) : 6'(fill);
        end
    end

endmodule

>>> sv/display_response_deframer.sv
// Display response deframer: one byte per accepted item, one byte per cycle when idle.
// A terminating byte gives one event next cycle, or a text frame of N characters
// is sent character by character, each through a RAM read and then an output load.
// Input is stalled while characters are being sent or the output register is held.
// Reset (rst_n, async, active low) clears fill, terminator run, page and output valid.
// Depends on dpr_pkg, dpr_ram, dpr_decode.
module display_response_deframer #(
    parameter int FRAME_MAX = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          received_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output dpr_pkg::kind_t      event_kind,
    output logic [7:0]          page_id,
    output logic [7:0]          widget_id,
    output logic [7:0]          touch_state,
    output logic [15:0]         coord_x,
    output logic [15:0]         coord_y,
    output logic [31:0]         number_value,
    output logic [7:0]          text_char,
    output logic [5:0]          text_length,
    output logic                refresh_hint,
    output logic                last_of_run
);
    import dpr_pkg::*;

    localparam int FW = $clog2(FRAME_MAX + 1);  // fill count, holds FRAME_MAX
    localparam int AW = $clog2(FRAME_MAX);      // store address

    // one-hot sequencer: idle takes bytes, read/send walk the text store
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [FW-1:0]                fill_reg, fill_next;
    logic [1:0]                   run_reg, run_next;
    logic [7:0]                   page_reg, page_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [5:0]                   tlen_reg, tlen_next;
    logic                         hint_reg, hint_next;
    logic                         out_valid_reg, out_valid_next;
    result_t                      res_reg, res_next;
    logic [HDR_LEN-1:0][7:0]      hdr_reg;

    dec_t                         dec;
    logic                         out_free;
    logic                         in_acc;
    logic                         is_term;
    logic                         wr_en;
    logic                         rd_en;
    logic [7:0]                   rd_data;
    logic                         last_char;

    // output register frees when it is empty or being taken this edge
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign in_acc   = in_valid && !in_stall;
    assign is_term  = (received_byte == TERM_BYTE);
    assign wr_en    = in_acc && !is_term && (fill_reg != FW'(FRAME_MAX));
    assign rd_en    = (state_reg == S_READ);
    assign last_char = ((6'(idx_reg) + 6'd1) == tlen_reg);

    dpr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_MAX)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (fill_reg[AW-1:0]),
        .wdata (received_byte),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    dpr_decode #(
        .FRAME_MAX (FRAME_MAX)
    ) u_decode (
        .hdr      (hdr_reg),
        .fill     (fill_reg),
        .page_cur (page_reg),
        .dec      (dec)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        run_next       = run_reg;
        page_next      = page_reg;
        idx_next       = idx_reg;
        tlen_next      = tlen_reg;
        hint_next      = hint_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (is_term)
                    begin
                        run_next = run_reg + 2'd1;
                        if (run_reg == 2'd2)
                        begin
                            // third 0xFF in a row closes the frame
                            run_next  = '0;
                            fill_next = '0;
                            if (fill_reg != '0)
                            begin
                                if (dec.page_set)
                                begin
                                    page_next = dec.new_page;
                                end
                                if (dec.is_text)
                                begin
                                    tlen_next  = dec.tlen;
                                    hint_next  = dec.hint;
                                    idx_next   = '0;
                                    state_next = S_READ;
                                end
                                else
                                begin
                                    res_next       = dec.res;
                                    out_valid_next = 1'b1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        run_next = '0;
                        if (fill_reg == FW'(FRAME_MAX))
                        begin
                            // store full: drop the frame, report overflow
                            fill_next      = '0;
                            res_next       = '0;
                            res_next.kind  = KIND_OVERFLOW;
                            res_next.last  = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                // rd_data holds until the next read, so waiting here is safe
                if (out_free)
                begin
                    res_next       = '0;
                    res_next.kind  = KIND_TEXT;
                    res_next.ch    = rd_data;
                    res_next.tlen  = tlen_reg;
                    res_next.hint  = hint_reg;
                    res_next.last  = last_char;
                    out_valid_next = 1'b1;
                    if (last_char)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            run_reg       <= '0;
            page_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            run_reg       <= run_next;
            page_reg      <= page_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        tlen_reg <= tlen_next;
        hint_reg <= hint_next;
        res_reg  <= res_next;
        // shadow of the leading bytes, written alongside the store
        for (int i = 0; i < HDR_LEN; i++)
        begin
            if (wr_en && (fill_reg == FW'(i)))
            begin
                hdr_reg[i] <= received_byte;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = res_reg.kind;
    assign page_id      = res_reg.page;
    assign widget_id    = res_reg.comp;
    assign touch_state  = res_reg.st;
    assign coord_x      = res_reg.x;
    assign coord_y      = res_reg.y;
    assign number_value = res_reg.num;
    assign text_char    = res_reg.ch;
    assign text_length  = res_reg.tlen;
    assign refresh_hint = res_reg.hint;
    assign last_of_run  = res_reg.last;

endmodule

>>> sv/dpr_checker.sv
// Port-level checks for the display response deframer, bound to the top level.
// Depends on dpr_pkg.
module dpr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input dpr_pkg::kind_t      event_kind,
    input logic [7:0]          page_id,
    input logic [7:0]          text_char,
    input logic [5:0]          text_length,
    input logic                last_of_run
);
    import dpr_pkg::*;

    // held item stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(text_char))
        else $error("output item changed while stalled");

    // single-result events always close their run
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind != KIND_TEXT) |-> last_of_run && (text_length == 6'd0))
        else $error("non-text event not marked last");

    // text characters carry a length and no page
    a_text_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == KIND_TEXT) |-> (text_length != 6'd0) && (page_id == 8'd0))
        else $error("text item fields wrong");

    // input held off while a text frame is still being sent; free again once the final
    // character sits in the output register and that register is free
    a_text_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (event_kind == KIND_TEXT) && !last_of_run
        |=> in_stall || (out_valid && last_of_run))
        else $error("input taken in the middle of a text frame");

endmodule

bind display_response_deframer dpr_checker u_dpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_kind  (event_kind),
    .page_id     (page_id),
    .text_char   (text_char),
    .text_length (text_length),
    .last_of_run (last_of_run)
);

>>> sim/dpr_event_checker.sv
// Scoreboard for the display response deframer: predicts events from accepted bytes
// and compares them with accepted output items. Depends on dpr_pkg.
`timescale 1ns / 100ps
module dpr_event_checker #(
    parameter int FRAME_MAX = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  logic [7:0]     received_byte,
    input  logic           out_valid,
    input  logic           out_stall,
    input  dpr_pkg::kind_t event_kind,
    input  logic [7:0]     page_id,
    input  logic [7:0]     widget_id,
    input  logic [7:0]     touch_state,
    input  logic [15:0]    coord_x,
    input  logic [15:0]    coord_y,
    input  logic [31:0]    number_value,
    input  logic [7:0]     text_char,
    input  logic [5:0]     text_length,
    input  logic           refresh_hint,
    input  logic           last_of_run,
    output int             mismatches,
    output int             pending
);
    import dpr_pkg::*;

    // predicted copy of the block's state
    logic [7:0]  frame_buf [FRAME_MAX];
    int unsigned buf_fill;
    int unsigned ff_run;
    logic [7:0]  cur_page;
    result_t     expected_events [$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
        buf_fill   = 0;
        ff_run     = 0;
        cur_page   = 8'h00;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    function automatic result_t single_event(input kind_t kind);
        result_t r;
        r      = '0;
        r.kind = kind;
        r.last = 1'b1;
        return r;
    endfunction

    // tag bytes are packed first-character-high
    function automatic bit has_prefix(input logic [55:0] tag, input int unsigned n);
        bit hit;
        hit = (buf_fill >= n);
        for (int unsigned i = 0; i < n && hit; i++)
            hit = (frame_buf[i] == tag[8 * (n - 1 - i) +: 8]);
        return hit;
    endfunction

    task automatic decode_frame();
        result_t     r;
        int unsigned tlen;
        logic        hint;
        hint = 1'b0;
        if (buf_fill >= 4 && frame_buf[0] == TAG_TOUCH)
        begin
            cur_page = frame_buf[1];
            r        = single_event(KIND_TOUCH);
            r.page   = frame_buf[1];
            r.comp   = frame_buf[2];
            r.st     = frame_buf[3];
            expected_events.push_back(r);
        end
        else if (buf_fill >= 6 && frame_buf[0] == TAG_COORD)
        begin
            r      = single_event(KIND_COORD);
            r.page = cur_page;
            r.st   = frame_buf[5];
            r.x    = {frame_buf[1], frame_buf[2]};
            r.y    = {frame_buf[3], frame_buf[4]};
            expected_events.push_back(r);
        end
        else if (buf_fill >= 5 && frame_buf[0] == TAG_NUMBER)
        begin
            r      = single_event(KIND_NUMBER);
            r.page = cur_page;
            r.num  = {frame_buf[4], frame_buf[3], frame_buf[2], frame_buf[1]};
            expected_events.push_back(r);
        end
        else
        begin
            if (buf_fill >= 6 && has_prefix({16'h0, PAGE_TAG}, 5))
            begin
                cur_page = frame_buf[5] - DIGIT_BASE;
                hint     = 1'b1;
            end
            else if (has_prefix(REFRESH_TAG, 7))
                hint = 1'b1;
            tlen = (buf_fill >= FRAME_MAX) ? FRAME_MAX - 1 : buf_fill;
            for (int unsigned i = 0; i < tlen; i++)
            begin
                r      = single_event(KIND_TEXT);
                r.ch   = frame_buf[i];
                r.tlen = tlen[5:0];
                r.hint = hint;
                r.last = (i + 1 == tlen);
                expected_events.push_back(r);
            end
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        if (b == TERM_BYTE)
        begin
            ff_run++;
            if (ff_run >= 3)
            begin
                if (buf_fill != 0)
                    decode_frame();
                buf_fill = 0;
                ff_run   = 0;
            end
        end
        else
        begin
            ff_run = 0;
            if (buf_fill < FRAME_MAX)
            begin
                frame_buf[buf_fill] = b;
                buf_fill++;
            end
            else
            begin
                buf_fill = 0;
                expected_events.push_back(single_event(KIND_OVERFLOW));
            end
        end
    endtask

    task automatic check_event();
        result_t e;
        if (expected_events.size() == 0)
            report_mismatch("unexpected event kind", 32'h0, event_kind);
        else
        begin
            e = expected_events.pop_front();
            if (event_kind   !== e.kind) report_mismatch("event_kind",   e.kind, event_kind);
            if (page_id      !== e.page) report_mismatch("page_id",      e.page, page_id);
            if (widget_id    !== e.comp) report_mismatch("widget_id",    e.comp, widget_id);
            if (touch_state  !== e.st)   report_mismatch("touch_state",  e.st,   touch_state);
            if (coord_x      !== e.x)    report_mismatch("coord_x",      e.x,    coord_x);
            if (coord_y      !== e.y)    report_mismatch("coord_y",      e.y,    coord_y);
            if (number_value !== e.num)  report_mismatch("number_value", e.num,  number_value);
            if (text_char    !== e.ch)   report_mismatch("text_char",    e.ch,   text_char);
            if (text_length  !== e.tlen) report_mismatch("text_length",  e.tlen, text_length);
            if (refresh_hint !== e.hint) report_mismatch("refresh_hint", e.hint, refresh_hint);
            if (last_of_run  !== e.last) report_mismatch("last_of_run",  e.last, last_of_run);
        end
    endtask

    // output first: an event never leaves in the cycle its byte is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_event();
            if (in_valid && !in_stall)
                deframe_byte(received_byte);
        end
        pending = expected_events.size();
    end

endmodule

>>> sim/tb_display_response_deframer.sv
// Testbench top for display_response_deframer: clock, reset, byte stimulus,
// receiver back-pressure, watchdog and verdict. Depends on dpr_pkg and dpr_event_checker.
`timescale 1ns / 100ps
module tb_display_response_deframer;
    import dpr_pkg::*;

    localparam int FRAME_MAX    = 32;
    // directed part sends about 230 bytes; random part tops it up
    localparam int RANDOM_ITEMS = 45;
    // longest correct quiet spell is the receiver hold-off below; several times that
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    // a full text frame drains one character at a time
    localparam int DRAIN_CYCLES = 100;

    typedef logic [7:0] byte_seq_t [$];

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  received_byte;
    logic        out_valid;
    logic        out_stall;
    kind_t       event_kind;
    logic [7:0]  page_id;
    logic [7:0]  widget_id;
    logic [7:0]  touch_state;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [31:0] number_value;
    logic [7:0]  text_char;
    logic [5:0]  text_length;
    logic        refresh_hint;
    logic        last_of_run;
    int          mismatches;
    int          pending;

    bit          calm     = 1'b0;   // no idling on either side once set
    bit          hold_req = 1'b0;   // asks the receiver for one long hold-off
    int          bytes_sent = 0;

    always #5 clk = ~clk;

    display_response_deframer #(
        .FRAME_MAX (FRAME_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .received_byte (received_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .page_id       (page_id),
        .widget_id     (widget_id),
        .touch_state   (touch_state),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .number_value  (number_value),
        .text_char     (text_char),
        .text_length   (text_length),
        .refresh_hint  (refresh_hint),
        .last_of_run   (last_of_run)
    );

    dpr_event_checker #(
        .FRAME_MAX (FRAME_MAX)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .received_byte (received_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .page_id       (page_id),
        .widget_id     (widget_id),
        .touch_state   (touch_state),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .number_value  (number_value),
        .text_char     (text_char),
        .text_length   (text_length),
        .refresh_hint  (refresh_hint),
        .last_of_run   (last_of_run),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Watchdog: counts cycles in which neither channel moves an item.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("FAIL");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    // The hold-off is timed here so the sender keeps offering and the block backs up.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall <= 0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // any byte that can sit inside a frame
    function automatic logic [7:0] body_byte();
        return 8'($urandom_range(0, 254));
    endfunction

    // Offer one item and return at the falling edge after it is taken.
    // Valid stays high between back-to-back items, so it is only written once per step.
    task automatic offer_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        received_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic offer_bytes(input byte_seq_t seq);
        foreach (seq[i])
            offer_byte(seq[i]);
    endtask

    // body followed by a plain three-byte terminator
    task automatic send_frame(input byte_seq_t body);
        offer_bytes(body);
        offer_bytes({TERM_BYTE, TERM_BYTE, TERM_BYTE});
    endtask

    task automatic send_text(input string s);
        byte_seq_t body;
        for (int i = 0; i < s.len(); i++)
            body.push_back(s[i]);
        send_frame(body);
    endtask

    // Mostly well-formed frames with random content; some noise, overflows,
    // long FF runs and broken terminators that glue frames together.
    task automatic random_frame();
        byte_seq_t body;
        int        pick;
        int        len;
        int        term;
        pick = $urandom_range(0, 99);
        len  = 0;
        if (pick < 15)
        begin
            body.push_back(TAG_TOUCH);
            len = $urandom_range(3, 6);
        end
        else if (pick < 30)
        begin
            body.push_back(TAG_COORD);
            len = $urandom_range(5, 8);
        end
        else if (pick < 42)
        begin
            body.push_back(TAG_NUMBER);
            len = $urandom_range(4, 7);
        end
        else if (pick < 50)
        begin
            body = {8'h70, 8'h61, 8'h67, 8'h65, 8'h3D};
            // usually a real digit, sometimes any byte at all
            body.push_back(($urandom_range(0, 3) != 0) ? 8'(8'h30 + $urandom_range(0, 9))
                                                       : body_byte());
            len = $urandom_range(0, 2);
        end
        else if (pick < 56)
        begin
            body = {8'h72, 8'h65, 8'h66, 8'h72, 8'h65, 8'h73, 8'h68};
            len  = $urandom_range(0, 3);
        end
        else if (pick < 62)
        begin
            // typed tag one or more bytes short of its minimum
            case ($urandom_range(0, 2))
                0:       begin body.push_back(TAG_TOUCH);  len = $urandom_range(0, 2); end
                1:       begin body.push_back(TAG_COORD);  len = $urandom_range(0, 4); end
                default: begin body.push_back(TAG_NUMBER); len = $urandom_range(0, 3); end
            endcase
        end
        else if (pick < 85)
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, FRAME_MAX)
                                              : $urandom_range(1, 12);
        else if (pick < 90)
            len = $urandom_range(FRAME_MAX + 1, FRAME_MAX + 4);
        else if (pick < 95)
        begin
            // noise, FF-heavy, no terminator of its own
            repeat ($urandom_range(1, 8))
                body.push_back(($urandom_range(0, 2) == 0) ? TERM_BYTE
                                                           : 8'($urandom_range(0, 255)));
            offer_bytes(body);
            return;
        end
        repeat (len)
            body.push_back(body_byte());
        offer_bytes(body);
        term = $urandom_range(0, 9);
        if (term == 0)
            repeat ($urandom_range(4, 5)) offer_byte(TERM_BYTE);
        else if (term == 1)
            offer_bytes({TERM_BYTE, TERM_BYTE});
        else
            offer_bytes({TERM_BYTE, TERM_BYTE, TERM_BYTE});
    endtask

    initial
    begin
        byte_seq_t body;
        int        random_start;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        received_byte = 8'h00;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // empty frame: no event at all
        offer_bytes({TERM_BYTE, TERM_BYTE, TERM_BYTE});
        // long receiver hold-off: the touch event sits in the output register
        // while the following frames keep being offered
        hold_req = 1'b1;
        // touch sets the page, coord and number then report it
        send_frame({TAG_TOUCH, 8'h03, 8'h07, 8'h01});
        send_frame({TAG_COORD, 8'h00, 8'h00, 8'hFE, 8'hFE, 8'h01});
        send_frame({TAG_NUMBER, 8'hFE, 8'hFE, 8'hFE, 8'hFE});
        send_frame({TAG_NUMBER, 8'h01, 8'h02, 8'h03, 8'h80, 8'h55});
        send_frame({TAG_TOUCH, 8'hFE, 8'h00, 8'hFE, 8'h7F});
        // typed tags too short fall back to text
        send_frame({TAG_TOUCH, 8'h01, 8'h02});
        send_frame({TAG_COORD, 8'h01, 8'h02, 8'h03, 8'h04});
        send_frame({TAG_NUMBER, 8'h01, 8'h02, 8'h03});
        // page change: digit, bare tag (no hint), non-digit wraps
        send_text("page=5");
        send_text("page=");
        send_frame({8'h70, 8'h61, 8'h67, 8'h65, 8'h3D, 8'h00});
        send_frame({TAG_COORD, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00});
        // refresh hint needs all seven characters
        send_text("refresh");
        send_text("refres");
        send_text("refreshed");
        send_frame({8'h00});
        // full-length text gets cut by one character
        body = {8'h41};
        repeat (FRAME_MAX - 1) body.push_back(body_byte());
        send_frame(body);
        // one byte too many: frame dropped with an overflow, then an empty terminator
        body = {TAG_TOUCH};
        repeat (FRAME_MAX) body.push_back(body_byte());
        send_frame(body);
        // broken run of FF bytes does not end the frame
        offer_bytes({8'h41, TERM_BYTE, TERM_BYTE, 8'h42, TERM_BYTE, TERM_BYTE, TERM_BYTE});
        // extra FF bytes after a terminator are cleared by the next data byte
        offer_bytes({8'h43, TERM_BYTE, TERM_BYTE, TERM_BYTE, TERM_BYTE, TERM_BYTE,
                     8'h44, TERM_BYTE, TERM_BYTE, TERM_BYTE});
        offer_bytes({TERM_BYTE, TERM_BYTE, TERM_BYTE, TERM_BYTE, TERM_BYTE, TERM_BYTE});

        // --- random ---
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_ITEMS)
        begin
            // final stretch runs flat out on both sides
            if (bytes_sent - random_start > RANDOM_ITEMS * 4 / 5)
                calm = 1'b1;
            random_frame();
        end
        // close any frame left open by noise or a broken terminator
        offer_bytes({TERM_BYTE, TERM_BYTE, TERM_BYTE});
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
